// ----- hw/rtl/mfde_pkg.sv -----
// shared constants and codes for the monochrome framebuffer draw engine
// no dependencies
package mfde_pkg;

   localparam int SCREEN_WIDTH  = 128;
   localparam int SCREEN_HEIGHT = 96;
   localparam int STORE_BYTES   = 1536;
   localparam int ROW_BYTES     = (SCREEN_WIDTH + 7) / 8;

   // coordinate width, wide enough for center plus or minus radius
   localparam int CW     = 12;
   localparam int X_W    = $clog2(SCREEN_WIDTH);
   localparam int ROW_W  = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
   localparam int BX_W   = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
   localparam int ADDR_W = $clog2(STORE_BYTES);
   localparam int IDX_W  = ROW_W + BX_W + 1;

   typedef enum logic [2:0] {
      CMD_CLEAR  = 3'd0,
      CMD_PIXEL  = 3'd1,
      CMD_HLINE  = 3'd2,
      CMD_VLINE  = 3'd3,
      CMD_BOX    = 3'd4,
      CMD_CIRCLE = 3'd5,
      CMD_READ   = 3'd6
   } cmd_type;

   typedef enum logic [1:0] {
      COL_BLACK  = 2'd0,
      COL_WHITE  = 2'd1,
      COL_INVERT = 2'd2,
      COL_NONE   = 2'd3
   } color_type;

endpackage

// ----- hw/rtl/mfde_ram.sv -----
// generic single port ram with registered read
// no dependencies
module mfde_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1536
) (
   input  logic                     clock,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic                     we,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata <= mem_ff[addr];
   end

endmodule

// ----- hw/rtl/mono_framebuffer_draw_engine_core.sv -----
// monochrome 1 bpp draw engine: command sequencer around one read-modify-write span unit
// depends on mfde_pkg and mfde_ram
// reset starts a clearing pass over all 1536 bytes, with req_ready low throughout
// drawing: each phase, drawn or empty, is planned in S_PLAN, then each byte is read (S_RD) and written (S_WR);
// each octant step passes S_CSTEP, and a closing plan ends the item before its result is handed over
// read byte: the result passes S_READ, S_READW and done_ff to rsp_valid; next item once the output register takes it
module mono_framebuffer_draw_engine_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_command,
   input  logic signed [10:0] req_x_a,
   input  logic signed [10:0] req_y_a,
   input  logic signed [10:0] req_x_b,
   input  logic signed [10:0] req_y_b,
   input  logic [7:0]         req_radius,
   input  logic [1:0]         req_outline_color,
   input  logic [1:0]         req_fill_color,
   input  logic [10:0]        req_byte_address,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_read_data
);

   localparam int CW = mfde_pkg::CW;
   localparam logic signed [CW-1:0] YMAX = CW'(mfde_pkg::SCREEN_HEIGHT - 1);
   localparam logic signed [CW-1:0] XMAX = CW'(mfde_pkg::SCREEN_WIDTH - 1);

   typedef enum logic [2:0] {
      S_INIT, S_IDLE, S_PLAN, S_RD, S_WR, S_CSTEP, S_READ, S_READW
   } state_type;

   // sequencer state, and the flag of a finished result waiting for the output register
   state_type state_ff;
   logic      done_ff;

   // captured item
   mfde_pkg::cmd_type   cmd_ff;
   logic signed [CW-1:0] xa_ff, ya_ff, xb_ff, yb_ff, r_ff;
   mfde_pkg::color_type oc_ff, fc_ff;
   logic [10:0]         addr_ff;
   logic [4:0]          phase_ff;

   // circle walker
   logic signed [CW-1:0] a_ff, b_ff, f_ff, dx_ff, dy_ff, pa_ff, pb_ff;

   // span unit
   logic [mfde_pkg::ROW_W-1:0]  row_ff, rhi_ff;
   logic [mfde_pkg::X_W-1:0]    xl_ff, xh_ff;
   logic [mfde_pkg::BX_W-1:0]   bx_ff;
   mfde_pkg::color_type         jc_ff;

   logic [mfde_pkg::ADDR_W-1:0] cnt_ff;
   logic                        rsp_valid_ff;
   logic [7:0]                  rsp_data_ff, res_ff;

   // ram port
   logic [mfde_pkg::ADDR_W-1:0] ram_addr;
   logic                        ram_we;
   logic [7:0]                  ram_wdata, ram_rdata;

   mfde_ram #(
      .WIDTH(8),
      .DEPTH(mfde_pkg::STORE_BYTES)
   ) u_ram (
      .clock(clock),
      .addr (ram_addr),
      .we   (ram_we),
      .wdata(ram_wdata),
      .rdata(ram_rdata)
   );

   assign req_ready     = (state_ff == S_IDLE) && !done_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;

   // ordered corners for hline, vline and box
   logic signed [CW-1:0] xmin, xmax, ymin, ymax;
   assign xmin = (xa_ff <= xb_ff) ? xa_ff : xb_ff;
   assign xmax = (xa_ff <= xb_ff) ? xb_ff : xa_ff;
   assign ymin = (ya_ff <= yb_ff) ? ya_ff : yb_ff;
   assign ymax = (ya_ff <= yb_ff) ? yb_ff : ya_ff;

   // job planner: which span the current phase asks for
   logic signed [CW-1:0] j_rlo, j_rhi, j_xlo, j_xhi, px, py;
   mfde_pkg::color_type  j_col;
   logic                 j_en, j_end, j_loop, j_plot;
   logic [4:0]           phase_nxt;

   always_comb begin
      j_rlo = '0; j_rhi = '0; j_xlo = '0; j_xhi = '0;
      px = '0; py = '0;
      j_col  = mfde_pkg::COL_NONE;
      j_en   = 1'b1;
      j_end  = 1'b0;
      j_loop = 1'b0;
      j_plot = 1'b0;
      phase_nxt = phase_ff + 5'd1;
      unique case (cmd_ff)
         mfde_pkg::CMD_CLEAR: begin
            if (phase_ff == 5'd0) begin
               j_rlo = '0; j_rhi = YMAX; j_xlo = '0; j_xhi = XMAX; j_col = oc_ff;
            end else begin
               j_end = 1'b1;
            end
         end
         mfde_pkg::CMD_PIXEL: begin
            if (phase_ff == 5'd0) begin
               j_rlo = ya_ff; j_rhi = ya_ff; j_xlo = xa_ff; j_xhi = xa_ff; j_col = oc_ff;
            end else begin
               j_end = 1'b1;
            end
         end
         mfde_pkg::CMD_HLINE: begin
            if (phase_ff == 5'd0) begin
               j_rlo = ya_ff; j_rhi = ya_ff; j_xlo = xmin; j_xhi = xmax; j_col = oc_ff;
            end else begin
               j_end = 1'b1;
            end
         end
         mfde_pkg::CMD_VLINE: begin
            if (phase_ff == 5'd0) begin
               j_rlo = ymin; j_rhi = ymax; j_xlo = xa_ff; j_xhi = xa_ff; j_col = oc_ff;
            end else begin
               j_end = 1'b1;
            end
         end
         mfde_pkg::CMD_BOX: begin
            j_xlo = xmin; j_xhi = xmax; j_col = oc_ff;
            case (phase_ff)
               5'd0: begin
                  j_rlo = ymin; j_rhi = ymin;
               end
               5'd1: begin
                  // bottom edge only when it is a different row
                  j_rlo = ymax; j_rhi = ymax; j_en = (ymin != ymax);
               end
               5'd2: begin
                  // left side over interior rows, empty when none exist
                  j_rlo = ymin + CW'(1); j_rhi = ymax - CW'(1); j_xhi = xmin;
               end
               5'd3: begin
                  j_rlo = ymin + CW'(1); j_rhi = ymax - CW'(1); j_xlo = xmax;
                  j_en = (xmin != xmax);
               end
               5'd4: begin
                  j_rlo = ymin; j_rhi = ymax; j_col = fc_ff;
               end
               default: j_end = 1'b1;
            endcase
         end
         mfde_pkg::CMD_CIRCLE: begin
            j_col  = oc_ff;
            j_plot = 1'b1;
            case (phase_ff)
               5'd0: begin
                  j_plot = 1'b0;
                  j_rlo = ya_ff; j_rhi = ya_ff;
                  j_xlo = xa_ff - r_ff; j_xhi = xa_ff + r_ff; j_col = fc_ff;
               end
               5'd1: begin px = xa_ff;        py = ya_ff + r_ff; end
               5'd2: begin px = xa_ff;        py = ya_ff - r_ff; end
               5'd3: begin px = xa_ff + r_ff; py = ya_ff;        end
               5'd4: begin px = xa_ff - r_ff; py = ya_ff;        end
               5'd5: j_loop = 1'b1;
               // fill rows of this octant step, repeated rows skipped
               5'd6, 5'd7: begin
                  j_plot = 1'b0;
                  j_rlo = (phase_ff == 5'd6) ? ya_ff + b_ff : ya_ff - b_ff;
                  j_rhi = j_rlo;
                  j_xlo = xa_ff - a_ff; j_xhi = xa_ff + a_ff; j_col = fc_ff;
                  j_en  = (pb_ff != b_ff);
               end
               5'd8, 5'd9: begin
                  j_plot = 1'b0;
                  j_rlo = (phase_ff == 5'd8) ? ya_ff + a_ff : ya_ff - a_ff;
                  j_rhi = j_rlo;
                  j_xlo = xa_ff - b_ff; j_xhi = xa_ff + b_ff; j_col = fc_ff;
                  j_en  = (pa_ff != a_ff) && (a_ff != b_ff);
               end
               // eight outline points
               5'd10: begin px = xa_ff + a_ff; py = ya_ff + b_ff; end
               5'd11: begin px = xa_ff - a_ff; py = ya_ff + b_ff; end
               5'd12: begin px = xa_ff + a_ff; py = ya_ff - b_ff; end
               5'd13: begin px = xa_ff - a_ff; py = ya_ff - b_ff; end
               5'd14: begin px = xa_ff + b_ff; py = ya_ff + a_ff; end
               5'd15: begin px = xa_ff - b_ff; py = ya_ff + a_ff; end
               5'd16: begin px = xa_ff + b_ff; py = ya_ff - a_ff; end
               5'd17: begin
                  px = xa_ff - b_ff; py = ya_ff - a_ff;
                  phase_nxt = 5'd5;
               end
               default: j_end = 1'b1;
            endcase
            if (j_plot) begin
               j_rlo = py; j_rhi = py; j_xlo = px; j_xhi = px;
            end
         end
         default: j_end = 1'b1;
      endcase
   end

   // clip the job to the screen
   logic signed [CW-1:0] c_rlo, c_rhi, c_xlo, c_xhi;
   logic                 j_empty;
   assign c_rlo   = (j_rlo < 0) ? '0 : j_rlo;
   assign c_rhi   = (j_rhi > YMAX) ? YMAX : j_rhi;
   assign c_xlo   = (j_xlo < 0) ? '0 : j_xlo;
   assign c_xhi   = (j_xhi > XMAX) ? XMAX : j_xhi;
   assign j_empty = !j_en || (j_col == mfde_pkg::COL_NONE) ||
                    (c_rlo > c_rhi) || (c_xlo > c_xhi);

   // circle octant step
   logic signed [CW-1:0] dy_n, f_1, dx_n, f_n, b_n;
   always_comb begin
      dy_n = dy_ff;
      f_1  = f_ff;
      b_n  = b_ff;
      if (f_ff >= 0) begin
         b_n  = b_ff - CW'(1);
         dy_n = dy_ff + CW'(2);
         f_1  = f_ff + dy_n;
      end
      dx_n = dx_ff + CW'(2);
      f_n  = f_1 + dx_n;
   end

   // span unit byte address and edge masks
   logic [mfde_pkg::IDX_W-1:0] idx;
   logic                       idx_ok, last_byte;
   logic [2:0]                 lo3, hi3;
   logic [7:0]                 mask, new_byte;

   assign idx = mfde_pkg::IDX_W'(row_ff) * mfde_pkg::IDX_W'(mfde_pkg::ROW_BYTES)
              + mfde_pkg::IDX_W'(bx_ff);
   assign idx_ok    = 32'(idx) < mfde_pkg::STORE_BYTES;
   assign last_byte = (bx_ff == mfde_pkg::BX_W'(xh_ff >> 3));
   assign lo3  = (bx_ff == mfde_pkg::BX_W'(xl_ff >> 3)) ? xl_ff[2:0] : 3'd0;
   assign hi3  = last_byte ? xh_ff[2:0] : 3'd7;
   assign mask = (8'hFF >> lo3) & (8'hFF << (3'd7 - hi3));

   always_comb begin
      case (jc_ff)
         mfde_pkg::COL_BLACK:  new_byte = ram_rdata & ~mask;
         mfde_pkg::COL_WHITE:  new_byte = ram_rdata | mask;
         mfde_pkg::COL_INVERT: new_byte = ram_rdata ^ mask;
         default:              new_byte = ram_rdata;
      endcase
   end

   always_comb begin
      ram_addr  = mfde_pkg::ADDR_W'(idx);
      ram_we    = 1'b0;
      ram_wdata = new_byte;
      unique case (state_ff)
         S_INIT: begin
            ram_addr  = cnt_ff;
            ram_we    = 1'b1;
            ram_wdata = 8'h00;
         end
         S_READ:  ram_addr = mfde_pkg::ADDR_W'(addr_ff);
         S_WR:    ram_we   = idx_ok;
         default: ram_addr = mfde_pkg::ADDR_W'(idx);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         done_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // hand the finished result to the output register once it is free
         if (done_ff && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
            rsp_data_ff  <= res_ff;
            done_ff      <= 1'b0;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_INIT: begin
               cnt_ff <= cnt_ff + mfde_pkg::ADDR_W'(1);
               if (cnt_ff == mfde_pkg::ADDR_W'(mfde_pkg::STORE_BYTES - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_valid && req_ready) begin
                  cmd_ff   <= mfde_pkg::cmd_type'(req_command);
                  xa_ff    <= {req_x_a[10], req_x_a};
                  ya_ff    <= {req_y_a[10], req_y_a};
                  xb_ff    <= {req_x_b[10], req_x_b};
                  yb_ff    <= {req_y_b[10], req_y_b};
                  r_ff     <= CW'(req_radius);
                  oc_ff    <= mfde_pkg::color_type'(req_outline_color);
                  fc_ff    <= mfde_pkg::color_type'(req_fill_color);
                  addr_ff  <= req_byte_address;
                  phase_ff <= '0;
                  // midpoint walker starts at the top of the circle
                  a_ff     <= '0;
                  b_ff     <= CW'(req_radius);
                  pa_ff    <= '0;
                  pb_ff    <= CW'(req_radius);
                  f_ff     <= CW'(1) - CW'(req_radius);
                  dx_ff    <= CW'(1);
                  dy_ff    <= -(CW'(req_radius) <<< 1);
                  res_ff   <= 8'h00;
                  if (req_command == mfde_pkg::CMD_READ) begin
                     state_ff <= S_READ;
                  end else begin
                     state_ff <= S_PLAN;
                  end
               end
            end
            S_PLAN: begin
               if (j_end) begin
                  done_ff  <= 1'b1;
                  state_ff <= S_IDLE;
               end else if (j_loop) begin
                  if (a_ff < b_ff) begin
                     state_ff <= S_CSTEP;
                  end else begin
                     done_ff  <= 1'b1;
                     state_ff <= S_IDLE;
                  end
               end else begin
                  phase_ff <= phase_nxt;
                  if (!j_empty) begin
                     row_ff   <= mfde_pkg::ROW_W'(c_rlo);
                     rhi_ff   <= mfde_pkg::ROW_W'(c_rhi);
                     xl_ff    <= mfde_pkg::X_W'(c_xlo);
                     xh_ff    <= mfde_pkg::X_W'(c_xhi);
                     bx_ff    <= mfde_pkg::BX_W'(c_xlo >>> 3);
                     jc_ff    <= j_col;
                     state_ff <= S_RD;
                  end
               end
            end
            S_RD: begin
               state_ff <= S_WR;
            end
            S_WR: begin
               if (last_byte) begin
                  if (row_ff == rhi_ff) begin
                     state_ff <= S_PLAN;
                  end else begin
                     row_ff   <= row_ff + mfde_pkg::ROW_W'(1);
                     bx_ff    <= mfde_pkg::BX_W'(xl_ff >> 3);
                     state_ff <= S_RD;
                  end
               end else begin
                  bx_ff    <= bx_ff + mfde_pkg::BX_W'(1);
                  state_ff <= S_RD;
               end
            end
            S_CSTEP: begin
               // previous step's point is kept for repeated-row suppression
               pa_ff    <= a_ff;
               pb_ff    <= b_ff;
               a_ff     <= a_ff + CW'(1);
               b_ff     <= b_n;
               dy_ff    <= dy_n;
               dx_ff    <= dx_n;
               f_ff     <= f_n;
               phase_ff <= 5'd6;
               state_ff <= S_PLAN;
            end
            S_READ: begin
               state_ff <= S_READW;
            end
            S_READW: begin
               res_ff   <= (32'(addr_ff) < mfde_pkg::STORE_BYTES) ? ram_rdata : 8'h00;
               done_ff  <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_INIT;
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   // clearing pass follows every reset
   a_init_after_reset: assert property (@(posedge clock) $fell(reset) |-> !req_ready)
      else $error("ready right after reset");

   // a written byte always touches at least one pixel
   a_mask_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WR) |-> (mask != 8'h00))
      else $error("empty byte mask");

   // span row walk never passes its last row
   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RD) |-> (row_ff <= rhi_ff))
      else $error("row past span end");

   // no new item while the previous result is still being handed over
   a_done_blocks: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !req_ready)
      else $error("ready with pending result");
`endif

endmodule
